// ----- rtl/sbdm_pkg.sv -----
// Package for the skin block density mask core.
// Holds the word types, configuration record, register indexes and sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package sbdm_pkg;

	localparam int DEF_MAX_WIDTH = 2048;
	localparam int DEF_TILE_SIZE = 5;
	localparam int MAX_HEIGHT    = 2048;
	localparam int ROW_W         = 11;
	localparam int COUNT_W       = 5;
	localparam int QUEUE_DEPTH   = 4;
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 12;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HUE_MIN         = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HUE_MAX         = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SAT_MIN_EXCL    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SAT_MAX         = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_COUNT_THRESHOLD = 3'd6;

	typedef struct packed {
		logic [8:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
	} pix_t;

	typedef struct packed {
		logic [8:0]         tile_column;
		logic [8:0]         tile_row;
		logic               tile_is_skin;
		logic [COUNT_W-1:0] skin_count;
		logic               frame_done;
	} tile_t;

	typedef struct packed {
		logic [11:0]        frame_width;
		logic [11:0]        frame_height;
		logic [8:0]         hue_min;
		logic [8:0]         hue_max;
		logic [7:0]         sat_min_excl;
		logic [7:0]         sat_max;
		logic [COUNT_W-1:0] count_threshold;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		frame_width:     12'd640,
		frame_height:    12'd480,
		hue_min:         9'd0,
		hue_max:         9'd50,
		sat_min_excl:    8'd58,
		sat_max:         8'd173,
		count_threshold: 5'd10
	};

endpackage

// ----- rtl/sbdm_front.sv -----
// Front end: accepts pixel words, classifies skin, tracks raster and tile position.
// Pushes one entry per pixel into the queue. Depends on sbdm_pkg.
`timescale 1ns / 1ps

module sbdm_front #(
	parameter int MAX_WIDTH = sbdm_pkg::DEF_MAX_WIDTH,
	parameter int TILE_SIZE = sbdm_pkg::DEF_TILE_SIZE,
	localparam int TILE_COLS = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE,
	localparam int TCW = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1,
	localparam int ENTRY_W = TCW + sbdm_pkg::ROW_W + 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sbdm_pkg::cfg_t     cfg,
	input  logic               pix_valid,
	output logic               pix_ready,
	input  sbdm_pkg::pix_t     pix,
	input  logic               q_full,
	input  logic               busy,
	output logic               push,
	output logic [ENTRY_W-1:0] entry
);

	localparam int PCW  = $clog2(MAX_WIDTH);
	localparam int TSW  = $clog2(TILE_SIZE);
	localparam int CMPW = (PCW > 12) ? PCW : 12;
	localparam int RW   = sbdm_pkg::ROW_W;

	typedef struct packed {
		logic [TCW-1:0] tc;
		logic [RW-1:0]  trow;
		logic           skin;
		logic           emit;
		logic           fdone;
	} entry_t;

	logic [PCW-1:0] pc_q;
	logic [RW-1:0]  pr_q;
	logic [TSW-1:0] cit_q;
	logic [TSW-1:0] rit_q;
	logic [TCW-1:0] tcol_q;
	logic [RW-1:0]  trow_q;

	logic [11:0] fw_m1;
	logic [11:0] fh_m1;
	logic        line_end;
	logic        last_row;
	logic        col_wrap;
	logic        row_wrap;
	logic        skin;
	entry_t      ent;

	// zero size acts as one
	assign fw_m1 = (cfg.frame_width == 12'd0) ? 12'd0 : cfg.frame_width - 12'd1;
	assign fh_m1 = (cfg.frame_height == 12'd0) ? 12'd0 : cfg.frame_height - 12'd1;

	assign line_end = (CMPW'(pc_q) >= CMPW'(fw_m1)) || (pc_q == PCW'(MAX_WIDTH - 1));
	assign last_row = ({1'b0, pr_q} >= fh_m1) || (pr_q == RW'(sbdm_pkg::MAX_HEIGHT - 1));
	assign col_wrap = (cit_q == TSW'(TILE_SIZE - 1));
	assign row_wrap = (rit_q == TSW'(TILE_SIZE - 1));

	assign skin = (pix.hue >= cfg.hue_min) && (pix.hue <= cfg.hue_max) &&
		(pix.saturation > cfg.sat_min_excl) && (pix.saturation <= cfg.sat_max) &&
		(pix.brightness != 8'd0);

	assign pix_ready = !q_full && !busy;
	assign push      = pix_valid && pix_ready;

	always_comb begin
		ent.tc    = tcol_q;
		ent.trow  = trow_q;
		ent.skin  = skin;
		ent.emit  = (col_wrap || line_end) && (row_wrap || last_row);
		ent.fdone = line_end && last_row;
	end

	assign entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			pr_q   <= '0;
			cit_q  <= '0;
			rit_q  <= '0;
			tcol_q <= '0;
			trow_q <= '0;
		end else if (push) begin
			if (line_end) begin
				pc_q   <= '0;
				cit_q  <= '0;
				tcol_q <= '0;
				if (last_row) begin
					pr_q   <= '0;
					rit_q  <= '0;
					trow_q <= '0;
				end else begin
					pr_q  <= pr_q + RW'(1);
					rit_q <= row_wrap ? '0 : rit_q + TSW'(1);
					if (row_wrap)
						trow_q <= trow_q + RW'(1);
				end
			end else begin
				pc_q  <= pc_q + PCW'(1);
				cit_q <= col_wrap ? '0 : cit_q + TSW'(1);
				if (col_wrap)
					tcol_q <= tcol_q + TCW'(1);
			end
		end
	end

endmodule

// ----- rtl/sbdm_queue.sv -----
// Short FIFO between front and back ends of the density mask core.
// Generic entry width; depth from sbdm_pkg.
`timescale 1ns / 1ps

module sbdm_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         full,
	output logic         empty
);

	localparam int DEPTH = sbdm_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);

	logic [W-1:0]     slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign head  = slot_q[rd_ptr_q];
	assign full  = (count_q == (PTR_W + 1)'(DEPTH));
	assign empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (PTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (PTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/sbdm_back.sv -----
// Back end: read-modify-write of the per-tile-column skin counters and the output register.
// Runs the post-reset clearing sweep of the counter memory. Depends on sbdm_pkg.
`timescale 1ns / 1ps

module sbdm_back #(
	parameter int MAX_WIDTH = sbdm_pkg::DEF_MAX_WIDTH,
	parameter int TILE_SIZE = sbdm_pkg::DEF_TILE_SIZE,
	localparam int TILE_COLS = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE,
	localparam int TCW = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1,
	localparam int ENTRY_W = TCW + sbdm_pkg::ROW_W + 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [sbdm_pkg::COUNT_W-1:0]   threshold,
	input  logic                           q_empty,
	input  logic [ENTRY_W-1:0]             head,
	output logic                           pop,
	output logic                           busy,
	output logic                           tile_valid,
	input  logic                           tile_ready,
	output sbdm_pkg::tile_t                tile
);

	localparam int RW = sbdm_pkg::ROW_W;
	localparam int CW = sbdm_pkg::COUNT_W;

	typedef struct packed {
		logic [TCW-1:0] tc;
		logic [RW-1:0]  trow;
		logic           skin;
		logic           emit;
		logic           fdone;
	} entry_t;

	logic [CW-1:0]   cnt_mem [TILE_COLS];
	logic            clr_busy_q;
	logic [TCW-1:0]  clr_idx_q;

	entry_t          hd;
	entry_t          e_s1;
	logic            v_s1;
	logic [CW-1:0]   rd_s1;
	logic            fwd_s1;
	logic [CW-1:0]   fwd_data_s1;

	logic            tile_valid_q;
	sbdm_pkg::tile_t tile_q;

	logic            leave_s1;
	logic [CW-1:0]   old_cnt;
	logic [CW-1:0]   new_cnt;
	logic [CW-1:0]   wr_data;

	assign hd = head;

	assign leave_s1 = v_s1 && (!e_s1.emit || !tile_valid_q || tile_ready);
	assign pop      = !q_empty && !clr_busy_q && (!v_s1 || leave_s1);
	assign busy     = clr_busy_q;

	// read data is stale when the word ahead wrote the same column on the read edge
	assign old_cnt = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign new_cnt = (e_s1.skin && old_cnt != sbdm_pkg::COUNT_MAX) ? old_cnt + CW'(1) : old_cnt;
	assign wr_data = e_s1.emit ? '0 : new_cnt;

	always_ff @(posedge clk) begin
		if (clr_busy_q)
			cnt_mem[clr_idx_q] <= '0;
		else if (leave_s1)
			cnt_mem[e_s1.tc] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_s1       <= cnt_mem[hd.tc];
			e_s1        <= hd;
			fwd_s1      <= leave_s1 && (e_s1.tc == hd.tc);
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + TCW'(1);
			if (clr_idx_q == TCW'(TILE_COLS - 1))
				clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			tile_valid_q <= 1'b0;
		end else begin
			if (pop)
				v_s1 <= 1'b1;
			else if (leave_s1)
				v_s1 <= 1'b0;
			if (leave_s1 && e_s1.emit)
				tile_valid_q <= 1'b1;
			else if (tile_ready)
				tile_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (leave_s1 && e_s1.emit) begin
			tile_q.tile_column  <= 9'(e_s1.tc);
			tile_q.tile_row     <= 9'(e_s1.trow);
			tile_q.tile_is_skin <= (new_cnt > threshold);
			tile_q.skin_count   <= new_cnt;
			tile_q.frame_done   <= e_s1.fdone;
		end
	end

	assign tile_valid = tile_valid_q;
	assign tile       = tile_q;

`ifndef SYNTHESIS
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!v_s1 && !tile_valid_q))
		else $error("pipeline active during counter clear");

	a_rise_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tile_valid_q) |-> $past(leave_s1 && e_s1.emit))
		else $error("tile word appeared without a committed tile end");

	a_flag_matches: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid_q |-> (tile_q.tile_is_skin == (tile_q.skin_count > threshold)))
		else $error("skin flag disagrees with count and threshold");
`endif

endmodule

// ----- rtl/skin_block_density_mask_core.sv -----
// Path: a pixel word passes the queue and the stage-1 register to the output register.
// Throughput: one pixel per clock while pix_ready is high; the counter memory reads one
// column and writes another each cycle, with the write forwarded when neighboring words
// hit the same column. Output stalls backpressure through the queue to pix_ready.
// Reset: configuration returns to defaults and the counter memory is swept to zero,
// one entry a cycle, ceil(MAX_WIDTH/TILE_SIZE) entries (410 by default), pix_ready low.
`timescale 1ns / 1ps

module skin_block_density_mask_core #(
	parameter int MAX_WIDTH = sbdm_pkg::DEF_MAX_WIDTH,
	parameter int TILE_SIZE = sbdm_pkg::DEF_TILE_SIZE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [sbdm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sbdm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  sbdm_pkg::pix_t                    pix,
	output logic                              tile_valid,
	input  logic                              tile_ready,
	output sbdm_pkg::tile_t                   tile
);

	localparam int TILE_COLS = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
	localparam int TCW = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
	localparam int ENTRY_W = TCW + sbdm_pkg::ROW_W + 3;

	sbdm_pkg::cfg_t     cfg_q;
	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_empty;
	logic               busy;
	logic [ENTRY_W-1:0] entry;
	logic [ENTRY_W-1:0] head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= sbdm_pkg::CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sbdm_pkg::REG_FRAME_WIDTH:     cfg_q.frame_width     <= cfg_data[11:0];
				sbdm_pkg::REG_FRAME_HEIGHT:    cfg_q.frame_height    <= cfg_data[11:0];
				sbdm_pkg::REG_HUE_MIN:         cfg_q.hue_min         <= cfg_data[8:0];
				sbdm_pkg::REG_HUE_MAX:         cfg_q.hue_max         <= cfg_data[8:0];
				sbdm_pkg::REG_SAT_MIN_EXCL:    cfg_q.sat_min_excl    <= cfg_data[7:0];
				sbdm_pkg::REG_SAT_MAX:         cfg_q.sat_max         <= cfg_data[7:0];
				sbdm_pkg::REG_COUNT_THRESHOLD: cfg_q.count_threshold <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	sbdm_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.TILE_SIZE (TILE_SIZE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.q_full    (q_full),
		.busy      (busy),
		.push      (push),
		.entry     (entry)
	);

	sbdm_queue #(
		.W (ENTRY_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (entry),
		.pop    (pop),
		.head   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	sbdm_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.TILE_SIZE (TILE_SIZE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.threshold  (cfg_q.count_threshold),
		.q_empty    (q_empty),
		.head       (head),
		.pop        (pop),
		.busy       (busy),
		.tile_valid (tile_valid),
		.tile_ready (tile_ready),
		.tile       (tile)
	);

endmodule

// ----- dv/skin_block_density_mask_core_tb.sv -----
// Self-checking testbench for skin_block_density_mask_core: random HSV pixel words and
// register settings, tile words checked against a scoreboard that predicts every tile.
// Depends on rtl/sbdm_pkg.sv and rtl/skin_block_density_mask_core.sv.
`timescale 1ns / 1ps

import sbdm_pkg::*;

class tile_scoreboard;
	localparam int TILE      = DEF_TILE_SIZE;
	localparam int TILE_COLS = (DEF_MAX_WIDTH + TILE - 1) / TILE;
	localparam int CNT_SAT   = 31;

	cfg_t             cfg;
	logic [4:0]       counts [TILE_COLS];
	int unsigned      col, row, col_in_tile, row_in_tile;
	tile_t            expected_tiles [$];
	int               errors;

	function new();
		cfg = CFG_RESET;
		foreach (counts[i]) counts[i] = '0;
		col = 0;
		row = 0;
		col_in_tile = 0;
		row_in_tile = 0;
		errors = 0;
	endfunction

	function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_FRAME_WIDTH:     cfg.frame_width = data;
			REG_FRAME_HEIGHT:    cfg.frame_height = data;
			REG_HUE_MIN:         cfg.hue_min = data[8:0];
			REG_HUE_MAX:         cfg.hue_max = data[8:0];
			REG_SAT_MIN_EXCL:    cfg.sat_min_excl = data[7:0];
			REG_SAT_MAX:         cfg.sat_max = data[7:0];
			REG_COUNT_THRESHOLD: cfg.count_threshold = data[4:0];
			default: ;
		endcase
	endfunction

	function int pending();
		return expected_tiles.size();
	endfunction

	// one accepted pixel word: update the tile counter, queue a tile word if one closes
	function void note_pixel(pix_t p);
		int unsigned w, h, tc, cnt;
		bit          skin, line_end, last_row;
		tile_t       t;
		w = cfg.frame_width;
		if (w == 0) w = 1;
		else if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
		h = cfg.frame_height;
		if (h == 0) h = 1;
		else if (h > MAX_HEIGHT) h = MAX_HEIGHT;

		skin = p.hue >= cfg.hue_min && p.hue <= cfg.hue_max &&
			p.saturation > cfg.sat_min_excl && p.saturation <= cfg.sat_max &&
			p.brightness != 0;

		tc = col / TILE;
		if (tc >= TILE_COLS) tc = TILE_COLS - 1;
		if (skin && counts[tc] < CNT_SAT) counts[tc] = counts[tc] + 1;

		line_end = col >= w - 1;
		last_row = row >= h - 1;
		if ((col_in_tile >= TILE - 1 || line_end) && (row_in_tile >= TILE - 1 || last_row)) begin
			cnt = counts[tc];
			t.tile_column  = tc[8:0];
			t.tile_row     = 9'(row / TILE);
			t.tile_is_skin = cnt > cfg.count_threshold;
			t.skin_count   = cnt[4:0];
			t.frame_done   = line_end && last_row;
			expected_tiles = {expected_tiles, t};
			counts[tc] = '0;
		end

		if (line_end) begin
			col = 0;
			col_in_tile = 0;
			if (last_row) begin
				row = 0;
				row_in_tile = 0;
			end else begin
				row++;
				row_in_tile = (row_in_tile >= TILE - 1) ? 0 : row_in_tile + 1;
			end
		end else begin
			col++;
			col_in_tile = (col_in_tile >= TILE - 1) ? 0 : col_in_tile + 1;
		end
	endfunction

	function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	function void check_tile(tile_t t);
		tile_t e;
		if (expected_tiles.size() == 0) begin
			$display("%0t unexpected tile word: expected none, actual col %0d row %0d",
				$time, t.tile_column, t.tile_row);
			errors++;
			return;
		end
		e = expected_tiles.pop_front();
		compare_field("tile_column", e.tile_column, t.tile_column);
		compare_field("tile_row", e.tile_row, t.tile_row);
		compare_field("tile_is_skin", e.tile_is_skin, t.tile_is_skin);
		compare_field("skin_count", e.skin_count, t.skin_count);
		compare_field("frame_done", e.frame_done, t.frame_done);
	endfunction
endclass

module skin_block_density_mask_core_tb;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
	localparam int STALL_LIMIT  = 3000;
	localparam int RANDOM_ITEMS = 800;
	localparam int LONG_RUN     = 400;
	localparam int DRAIN_CYCLES = 4;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   pix_valid;
	logic                   pix_ready;
	pix_t                   pix;
	logic                   tile_valid;
	logic                   tile_ready;
	tile_t                  tile;

	tile_scoreboard sb = new();
	bit             no_pix_gaps;
	int             idle_cycles;

	skin_block_density_mask_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix        (pix),
		.tile_valid (tile_valid),
		.tile_ready (tile_ready),
		.tile       (tile)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 2);
		if (r < 96) return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// sample everything at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) sb.set_reg(cfg_index, cfg_data);
			if (pix_valid && pix_ready) sb.note_pixel(pix);
			if (tile_valid && tile_ready) sb.check_tile(tile);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pix_valid && pix_ready) || (tile_valid && tile_ready) || cfg_wr_en) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// tile sink: ready runs of random length, with long stall-free stretches now and then
	initial begin
		int len;
		tile_ready = 1'b0;
		forever begin
			@(negedge clk);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
			tile_ready <= 1'b1;
			repeat (len - 1) @(negedge clk);
			@(negedge clk);
			tile_ready <= 1'b0;
			repeat (gap_len() - 1) @(negedge clk);
		end
	end

	task automatic send_pixel(pix_t p);
		int gap;
		@(negedge clk);
		gap = (no_pix_gaps || $urandom_range(0, 1) == 0) ? 0 : gap_len();
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix       <= p;
		pix_valid <= 1'b1;
		do @(posedge clk); while (!pix_ready);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// stop the pixel stream and wait for every outstanding tile word
	task automatic drain();
		@(negedge clk);
		pix_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic pix_t make_pixel(int skin_pct);
		pix_t p;
		p = pix_t'($urandom);
		if ($urandom_range(0, 99) < skin_pct && sb.cfg.hue_min <= sb.cfg.hue_max &&
				sb.cfg.sat_min_excl < sb.cfg.sat_max) begin
			p.hue        = 9'($urandom_range(sb.cfg.hue_min, sb.cfg.hue_max));
			p.saturation = 8'($urandom_range(sb.cfg.sat_min_excl + 1, sb.cfg.sat_max));
			p.brightness = 8'($urandom_range(1, 255));
		end else if ($urandom_range(0, 3) == 0) begin
			p.brightness = '0;
		end
		return p;
	endfunction

	task automatic run_pixels(int n, int skin_pct);
		repeat (n) send_pixel(make_pixel(skin_pct));
	endtask

	task automatic program_random();
		logic [8:0] hlo, hhi;
		logic [7:0] slo, shi;
		int         r;
		if ($urandom_range(0, 9) < 7) begin
			r = $urandom_range(0, 19);
			if (r == 0) write_reg(REG_FRAME_WIDTH, '0);
			else if (r == 1) write_reg(REG_FRAME_WIDTH, 12'($urandom_range(2049, 4095)));
			else write_reg(REG_FRAME_WIDTH, 12'($urandom_range(1, 23)));
			r = $urandom_range(0, 19);
			if (r == 0) write_reg(REG_FRAME_HEIGHT, '0);
			else write_reg(REG_FRAME_HEIGHT, 12'($urandom_range(1, 12)));
		end
		if ($urandom_range(0, 4) == 0) begin
			hlo = 9'($urandom);
			hhi = 9'($urandom);
		end else begin
			hlo = 9'($urandom_range(0, 60));
			hhi = 9'($urandom_range(hlo, 359));
		end
		if ($urandom_range(0, 4) == 0) begin
			slo = 8'($urandom);
			shi = 8'($urandom);
		end else begin
			slo = 8'($urandom_range(0, 120));
			shi = 8'($urandom_range(slo + 1, 255));
		end
		// upper data bits are junk and must be dropped
		write_reg(REG_HUE_MIN, {3'($urandom), hlo});
		write_reg(REG_HUE_MAX, {3'($urandom), hhi});
		write_reg(REG_SAT_MIN_EXCL, {4'($urandom), slo});
		write_reg(REG_SAT_MAX, {4'($urandom), shi});
		r = $urandom_range(0, 9);
		if (r == 0) write_reg(REG_COUNT_THRESHOLD, {7'($urandom), 5'd0});
		else if (r == 1) write_reg(REG_COUNT_THRESHOLD, {7'($urandom), 5'd31});
		else write_reg(REG_COUNT_THRESHOLD, {7'($urandom), 5'($urandom_range(0, 25))});
		if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 12'($urandom));
		end_writes();
	endtask

	initial begin
		int done_items;
		int n;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		pix_valid   = 1'b0;
		pix         = '0;
		no_pix_gaps = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: edges of the hue, saturation and value tests
		send_pixel('{hue: 9'd0, saturation: 8'd59, brightness: 8'd1});
		send_pixel('{hue: 9'd50, saturation: 8'd173, brightness: 8'd255});
		send_pixel('{hue: 9'd51, saturation: 8'd100, brightness: 8'd100});
		send_pixel('{hue: 9'd20, saturation: 8'd58, brightness: 8'd100});
		send_pixel('{hue: 9'd20, saturation: 8'd174, brightness: 8'd100});
		send_pixel('{hue: 9'd20, saturation: 8'd100, brightness: 8'd0});
		send_pixel('{hue: 9'd359, saturation: 8'd255, brightness: 8'd255});
		send_pixel('{hue: 9'd511, saturation: 8'd255, brightness: 8'd255});
		send_pixel('{hue: 9'd0, saturation: 8'd0, brightness: 8'd0});
		send_pixel('{hue: 9'd25, saturation: 8'd120, brightness: 8'd7});
		drain();

		// shrink the frame mid-line: the next word ends the line
		write_reg(REG_FRAME_WIDTH, 12'd3);
		write_reg(REG_FRAME_HEIGHT, 12'd2);
		write_reg(REG_COUNT_THRESHOLD, 12'hFE0);
		write_reg(REG_UNUSED, 12'hFFF);
		end_writes();
		repeat (7) send_pixel('{hue: 9'd10, saturation: 8'd100, brightness: 8'd200});
		drain();

		// zero sizes act as one pixel per frame; empty hue range, then empty sat range
		write_reg(REG_FRAME_WIDTH, 12'd0);
		write_reg(REG_FRAME_HEIGHT, 12'd0);
		write_reg(REG_HUE_MIN, 12'd100);
		write_reg(REG_HUE_MAX, 12'd20);
		end_writes();
		send_pixel('{hue: 9'd50, saturation: 8'd100, brightness: 8'd9});
		send_pixel('{hue: 9'd100, saturation: 8'd100, brightness: 8'd9});
		drain();
		write_reg(REG_HUE_MIN, 12'd0);
		write_reg(REG_HUE_MAX, 12'd359);
		write_reg(REG_SAT_MIN_EXCL, 12'd200);
		write_reg(REG_SAT_MAX, 12'd200);
		end_writes();
		send_pixel('{hue: 9'd50, saturation: 8'd200, brightness: 8'd9});
		drain();
		write_reg(REG_SAT_MIN_EXCL, 12'd0);
		write_reg(REG_SAT_MAX, 12'd255);
		write_reg(REG_COUNT_THRESHOLD, 12'd25);
		end_writes();
		send_pixel('{hue: 9'd50, saturation: 8'd255, brightness: 8'd9});
		drain();

		// oversized width: a long stretch of one line that is clamped to the largest width
		write_reg(REG_FRAME_WIDTH, 12'($urandom_range(2048, 4095)));
		write_reg(REG_FRAME_HEIGHT, 12'd1);
		write_reg(REG_COUNT_THRESHOLD, 12'd12);
		end_writes();
		run_pixels(LONG_RUN, 80);
		drain();

		// oversized height with a one-pixel line: tiles close every fifth line
		write_reg(REG_FRAME_WIDTH, 12'd1);
		write_reg(REG_FRAME_HEIGHT, 12'hFFF);
		write_reg(REG_COUNT_THRESHOLD, 12'd2);
		end_writes();
		no_pix_gaps = 1'b1;
		run_pixels(LONG_RUN, 60);
		drain();

		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			program_random();
			no_pix_gaps = $urandom_range(0, 3) == 0;
			n = $urandom_range(20, 150);
			run_pixels(n, $urandom_range(0, 4) == 0 ? $urandom_range(0, 100) : 95);
			done_items += n;
			drain();
		end

		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
